// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/kst_pkg.sv =====
`default_nettype none
package kst_pkg;

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int ENTRY_W  = 5;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WALK   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

endpackage
`default_nettype wire

// ===== sv/keyed_slot_table_unit.sv =====
// Add, search and remove scan slots in order and stop at the first hit: the result
// beat is registered from the RAM read of the hit slot; if none hits, add reports full
// and search or remove report a miss. Walk sends one beat per valid slot, or one miss
// beat if none is valid; clear empties every slot and answers with a single beat. One
// command at a time: the next request beat can be taken in the cycle after the last
// result is loaded, and the slot scan stalls while a result beat waits. Reset clears
// the valid bits, the entry count and the handshakes at once; RAM is not cleared.
`default_nettype none
module keyed_slot_table_unit #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [kst_pkg::CMD_W-1:0]      cmd,
	input  logic [kst_pkg::KEY_W-1:0]      req_key,
	input  logic [kst_pkg::VAL_W-1:0]      req_value,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [kst_pkg::STATUS_W-1:0]   status,
	output logic [kst_pkg::SLOT_W-1:0]     slot,
	output logic [kst_pkg::KEY_W-1:0]      key_out,
	output logic [kst_pkg::VAL_W-1:0]      value_out,
	output logic [kst_pkg::ENTRY_W-1:0]    entries,
	output logic                           last
);

	import kst_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = KEY_W + VALUE_BITS;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CLR} state_t;

	state_t                state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         idx_q;
	logic                  iss_q;
	logic                  vld_s1;
	logic [AW-1:0]         idx_s1;
	logic [DEPTH-1:0]      valid_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         walk_q;

	logic                  rsp_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [KEY_W-1:0]      key_out_q;
	logic [VAL_W-1:0]      value_out_q;
	logic [ENTRY_W-1:0]    entries_q;
	logic                  last_q;

	logic [AW-1:0]         ram_rd_addr;
	logic [MW-1:0]         ram_rd_data;
	logic                  ram_wr_en;
	logic [KEY_W-1:0]      rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic [63:0]           req_val64;
	logic [63:0]           rd_val64;
	logic [63:0]           val_q64;

	logic                  out_free;
	logic                  slot_vld;
	logic                  final_slot;
	logic                  hit;
	logic                  need_emit;
	logic                  stall;
	logic                  fire;
	logic                  walk_last;
	logic                  done;
	logic [CW-1:0]         em_count;
	logic [STATUS_W-1:0]   em_status;
	logic [SLOT_W-1:0]     em_slot;
	logic [KEY_W-1:0]      em_key;
	logic [VAL_W-1:0]      em_value;
	logic                  em_last;

	assign rd_key    = ram_rd_data[MW-1 -: KEY_W];
	assign rd_val    = ram_rd_data[VALUE_BITS-1:0];
	assign req_val64 = 64'(req_value);
	assign rd_val64  = 64'(rd_val);
	assign val_q64   = 64'(val_q);

	assign out_free   = !rsp_valid_q || rsp_ready;
	assign slot_vld   = valid_q[idx_s1];
	assign final_slot = (idx_s1 == AW'(DEPTH - 1));
	assign walk_last  = (CW'(walk_q + 1'b1) == count_q);

	always_comb begin
		unique case (cmd_q)
			CMD_ADD:    hit = !slot_vld;
			CMD_SEARCH: hit = slot_vld && (rd_key == key_q);
			CMD_REMOVE: hit = slot_vld && (rd_key == key_q);
			CMD_WALK:   hit = slot_vld;
			default:    hit = 1'b0;
		endcase
	end

	assign need_emit = (state_q == S_SCAN) && vld_s1 && (hit || final_slot);
	assign stall     = need_emit && !out_free;
	assign fire      = need_emit && out_free;
	assign done      = (cmd_q == CMD_WALK) ? ((hit && walk_last) || (!hit && final_slot)) : 1'b1;
	assign ram_wr_en = fire && hit && (cmd_q == CMD_ADD);
	assign ram_rd_addr = stall ? idx_s1 : idx_q;

	always_comb begin
		em_count  = count_q;
		em_status = ST_OK;
		em_slot   = '0;
		em_key    = '0;
		em_value  = '0;
		em_last   = 1'b1;
		if (hit) begin
			em_slot  = SLOT_W'(idx_s1);
			em_key   = rd_key;
			em_value = rd_val64[VAL_W-1:0];
			if (cmd_q == CMD_ADD) begin
				em_key   = key_q;
				em_value = val_q64[VAL_W-1:0];
				em_count = CW'(count_q + 1'b1);
			end else if (cmd_q == CMD_REMOVE) begin
				em_count = CW'(count_q - 1'b1);
			end else if (cmd_q == CMD_WALK) begin
				em_last = walk_last;
			end
		end else begin
			em_status = (cmd_q == CMD_ADD) ? ST_FULL : ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			key_q       <= '0;
			val_q       <= '0;
			idx_q       <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			walk_q      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= '0;
			slot_q      <= '0;
			key_out_q   <= '0;
			value_out_q <= '0;
			entries_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q  <= cmd;
						key_q  <= req_key;
						val_q  <= req_val64[VALUE_BITS-1:0];
						idx_q  <= '0;
						vld_s1 <= 1'b0;
						walk_q <= '0;
						unique case (cmd)
							CMD_ADD, CMD_SEARCH, CMD_REMOVE, CMD_WALK: begin
								iss_q   <= 1'b1;
								state_q <= S_SCAN;
							end
							CMD_CLEAR: begin
								iss_q   <= 1'b0;
								state_q <= S_CLR;
							end
							default: begin
								iss_q <= 1'b0;
							end
						endcase
					end
				end
				S_CLR: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						status_q    <= ST_OK;
						slot_q      <= '0;
						key_out_q   <= '0;
						value_out_q <= '0;
						entries_q   <= '0;
						last_q      <= 1'b1;
						valid_q     <= '0;
						count_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						vld_s1 <= iss_q;
						idx_s1 <= idx_q;
						if (iss_q) begin
							if (idx_q == AW'(DEPTH - 1)) begin
								iss_q <= 1'b0;
							end else begin
								idx_q <= AW'(idx_q + 1'b1);
							end
						end
						if (fire) begin
							rsp_valid_q <= 1'b1;
							status_q    <= em_status;
							slot_q      <= em_slot;
							key_out_q   <= em_key;
							value_out_q <= em_value;
							entries_q   <= ENTRY_W'(em_count);
							last_q      <= em_last;
							count_q     <= em_count;
							if (hit && (cmd_q == CMD_ADD)) begin
								valid_q[idx_s1] <= 1'b1;
							end
							if (hit && (cmd_q == CMD_REMOVE)) begin
								valid_q[idx_s1] <= 1'b0;
							end
							if (hit && (cmd_q == CMD_WALK)) begin
								walk_q <= CW'(walk_q + 1'b1);
							end
							if (done) begin
								state_q <= S_IDLE;
								iss_q   <= 1'b0;
								vld_s1  <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	kst_ram #(
		.WIDTH(MW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(idx_s1),
		.wr_data({key_q, val_q}),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign key_out   = key_out_q;
	assign value_out = value_out_q;
	assign entries   = entries_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== sv/kst_ram.sv =====
`default_nettype none
module kst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== sv/kst_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module kst_checker #(
	parameter int DEPTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [kst_pkg::CMD_W-1:0]    cmd,
	input logic [kst_pkg::KEY_W-1:0]    req_key,
	input logic [kst_pkg::VAL_W-1:0]    req_value,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [kst_pkg::STATUS_W-1:0] status,
	input logic [kst_pkg::SLOT_W-1:0]   slot,
	input logic [kst_pkg::KEY_W-1:0]    key_out,
	input logic [kst_pkg::VAL_W-1:0]    value_out,
	input logic [kst_pkg::ENTRY_W-1:0]  entries,
	input logic                         last
);

	import kst_pkg::*;

	// A waiting result beat must not change.
	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable({status, slot, key_out, value_out, entries, last}))

	// Every failure status ends its command.
	`ASSERT_IMP(a_fail_last, clk, arst_n, rsp_valid && (status != ST_OK), last)

	// A full report only comes when every slot is taken.
	`ASSERT_IMP(a_full_count, clk, arst_n, rsp_valid && (status == ST_FULL),
		entries == ENTRY_W'(DEPTH))

	// While a walk still has beats to send, no request beat is taken.
	`ASSERT_IMP(a_one_cmd, clk, arst_n, rsp_valid && !last, !req_ready)

	// A waiting request beat must not change.
	`ASSERT_NXT(a_req_hold, clk, arst_n, req_valid && !req_ready,
		req_valid && $stable({cmd, req_key, req_value}))

endmodule

bind keyed_slot_table_unit kst_checker #(.DEPTH(DEPTH)) u_kst_checker (.*);
`default_nettype wire
